[rtl/nearest_point_pick_assert.svh]
// assertion macros for the nearest point pick rtl
`ifndef NEAREST_POINT_PICK_ASSERT_SVH
`define NEAREST_POINT_PICK_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define NPP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define NPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/npp_pkg.sv]
// types and constants for the nearest point pick block
package npp_pkg;

    localparam int POS_W       = 16;
    localparam int SCALE_W     = 13;
    localparam int SIZE_W      = 8;
    localparam int COUNT_W     = 9;
    localparam int FRAC_SHIFT  = 8;
    localparam int PROD_W      = POS_W + SCALE_W;
    localparam int POS_PIX_W   = PROD_W - FRAC_SHIFT;
    localparam int LIMIT_SHIFT = 14;
    localparam int LIMIT_W     = 2 * SIZE_W + LIMIT_SHIFT;
    localparam int MODE_W      = 2;
    localparam int INDEX_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER_SIZE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT  = 2'd3;

    localparam logic [SCALE_W-1:0] RESET_IMAGE_WIDTH  = 13'd1024;
    localparam logic [SCALE_W-1:0] RESET_IMAGE_HEIGHT = 13'd1024;
    localparam logic [SIZE_W-1:0]  RESET_MARKER_SIZE  = 8'd16;
    localparam logic [COUNT_W-1:0] RESET_ENTRY_COUNT  = 9'd0;

    typedef struct packed {
        logic [SCALE_W-1:0] image_width;
        logic [SCALE_W-1:0] image_height;
        logic [SIZE_W-1:0]  marker_size;
        logic [COUNT_W-1:0] entry_count;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic picked;
    } scan_tag_t;

endpackage

[rtl/nearest_point_pick.sv]
// top level of the nearest point pick block: configuration registers and datapath wiring
//
// A write request (mode 0) stores its entry at the accepting edge and the block is
// ready again in the next cycle. A query request (mode 1, or 2 to also mark the hit)
// reads entries 0 to min(entry_count, MAX_ENTRIES) - 1 of the point table one per
// cycle through one read address shared by both table memories, then drains the
// registered table read and a three-stage distance pipeline. The result is shown
// with done high for exactly one cycle, in the cycle that busy falls, and must be
// taken then: there is no way to hold it. Configuration writes are taken at any edge
// with cfg_we high and must only be issued while busy is low.
module nearest_point_pick
    import npp_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int PIXEL_BITS  = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [MODE_W-1:0]      mode,
    input  logic [INDEX_W-1:0]     entry_index,
    input  logic [POS_W-1:0]       point_x,
    input  logic [POS_W-1:0]       point_y,
    input  logic                   point_picked,
    input  logic [PIXEL_BITS-1:0]  cursor_x,
    input  logic [PIXEL_BITS-1:0]  cursor_y,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   done,
    output logic                   found,
    output logic [INDEX_W-1:0]     hit_index,
    output logic                   hit_was_picked
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = PIXEL_BITS + FRAC_SHIFT;
    localparam int DW   = (CW > POS_PIX_W) ? CW : POS_PIX_W;
    localparam int SQ_W = 2 * DW;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;

    logic             pos_we;
    logic             pick_we;
    logic [AW-1:0]    wr_addr;
    logic             wr_pick;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [POS_W-1:0] rd_x;
    logic [POS_W-1:0] rd_y;
    logic             rd_pick;
    scan_tag_t        tag_rd;
    logic [AW-1:0]    idx_rd;
    logic [PIXEL_BITS-1:0] cur_x;
    logic [PIXEL_BITS-1:0] cur_y;
    scan_tag_t        pipe_tag;
    logic [AW-1:0]    pipe_idx;
    logic [SQ_W-1:0]  sq_x;
    logic [SQ_W-1:0]  sq_y;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[SCALE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[SCALE_W-1:0];
                REG_MARKER_SIZE:  cfg_next.marker_size  = cfg_data[SIZE_W-1:0];
                REG_ENTRY_COUNT:  cfg_next.entry_count  = cfg_data[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= RESET_IMAGE_WIDTH;
            cfg_reg.image_height <= RESET_IMAGE_HEIGHT;
            cfg_reg.marker_size  <= RESET_MARKER_SIZE;
            cfg_reg.entry_count  <= RESET_ENTRY_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    npp_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .pos_we  (pos_we),
        .pick_we (pick_we),
        .wr_addr (wr_addr),
        .wr_x    (point_x),
        .wr_y    (point_y),
        .wr_pick (wr_pick),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y),
        .rd_pick (rd_pick)
    );

    npp_dist #(
        .AW         (AW),
        .PIXEL_BITS (PIXEL_BITS),
        .SQ_W       (SQ_W)
    ) u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag_in       (tag_rd),
        .idx_in       (idx_rd),
        .pos_x        (rd_x),
        .pos_y        (rd_y),
        .pos_picked   (rd_pick),
        .cur_x        (cur_x),
        .cur_y        (cur_y),
        .image_width  (cfg_reg.image_width),
        .image_height (cfg_reg.image_height),
        .tag_out      (pipe_tag),
        .idx_out      (pipe_idx),
        .sq_x         (sq_x),
        .sq_y         (sq_y)
    );

    npp_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .PIXEL_BITS  (PIXEL_BITS),
        .SQ_W        (SQ_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .entry_index    (entry_index),
        .point_picked   (point_picked),
        .cursor_x       (cursor_x),
        .cursor_y       (cursor_y),
        .marker_size    (cfg_reg.marker_size),
        .entry_count    (cfg_reg.entry_count),
        .pos_we         (pos_we),
        .pick_we        (pick_we),
        .wr_addr        (wr_addr),
        .wr_pick        (wr_pick),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .tag_rd         (tag_rd),
        .idx_rd         (idx_rd),
        .cur_x          (cur_x),
        .cur_y          (cur_y),
        .pipe_tag       (pipe_tag),
        .pipe_idx       (pipe_idx),
        .sq_x           (sq_x),
        .sq_y           (sq_y),
        .done           (done),
        .found          (found),
        .hit_index      (hit_index),
        .hit_was_picked (hit_was_picked)
    );

endmodule

[rtl/npp_table.sv]
// point table memories: positions and picked flags, registered reads
module npp_table
    import npp_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic             clk,
    input  logic             pos_we,
    input  logic             pick_we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [POS_W-1:0] wr_x,
    input  logic [POS_W-1:0] wr_y,
    input  logic             wr_pick,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [POS_W-1:0] rd_x,
    output logic [POS_W-1:0] rd_y,
    output logic             rd_pick
);

    logic [2*POS_W-1:0] pos_mem [DEPTH];
    logic               pick_mem [DEPTH];
    logic [2*POS_W-1:0] rd_pos_reg;
    logic               rd_pick_reg;

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[wr_addr] <= {wr_x, wr_y};
        end
        if (rd_en)
        begin
            rd_pos_reg <= pos_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pick_we)
        begin
            pick_mem[wr_addr] <= wr_pick;
        end
        if (rd_en)
        begin
            rd_pick_reg <= pick_mem[rd_addr];
        end
    end

    assign rd_x    = rd_pos_reg[2*POS_W-1:POS_W];
    assign rd_y    = rd_pos_reg[POS_W-1:0];
    assign rd_pick = rd_pick_reg;

endmodule

[rtl/npp_dist.sv]
// distance pipeline: scale to pixels, absolute difference, square
module npp_dist
    import npp_pkg::*;
#(
    parameter int AW         = 8,
    parameter int PIXEL_BITS = 12,
    parameter int SQ_W       = 42
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  scan_tag_t             tag_in,
    input  logic [AW-1:0]         idx_in,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic                  pos_picked,
    input  logic [PIXEL_BITS-1:0] cur_x,
    input  logic [PIXEL_BITS-1:0] cur_y,
    input  logic [SCALE_W-1:0]    image_width,
    input  logic [SCALE_W-1:0]    image_height,
    output scan_tag_t             tag_out,
    output logic [AW-1:0]         idx_out,
    output logic [SQ_W-1:0]       sq_x,
    output logic [SQ_W-1:0]       sq_y
);

    localparam int CW = PIXEL_BITS + FRAC_SHIFT;
    localparam int DW = SQ_W / 2;

    logic [PROD_W-1:0]    prod_x;
    logic [PROD_W-1:0]    prod_y;
    logic [DW-1:0]        cq_x;
    logic [DW-1:0]        cq_y;
    logic [DW-1:0]        pe_x;
    logic [DW-1:0]        pe_y;
    logic [DW-1:0]        ad_x;
    logic [DW-1:0]        ad_y;

    scan_tag_t            tag1_reg;
    scan_tag_t            tag2_reg;
    scan_tag_t            tag3_reg;
    logic [AW-1:0]        idx1_reg;
    logic [AW-1:0]        idx2_reg;
    logic [AW-1:0]        idx3_reg;
    logic [POS_PIX_W-1:0] px_reg;
    logic [POS_PIX_W-1:0] py_reg;
    logic [DW-1:0]        ax_reg;
    logic [DW-1:0]        ay_reg;
    logic [SQ_W-1:0]      sqx_reg;
    logic [SQ_W-1:0]      sqy_reg;

    // entry position in q.16 pixels (q.8 after the shift into px_reg/py_reg)
    assign prod_x = PROD_W'(pos_x) * PROD_W'(image_width);
    assign prod_y = PROD_W'(pos_y) * PROD_W'(image_height);

    // cursor in q.8 pixels
    assign cq_x = DW'({cur_x, {FRAC_SHIFT{1'b0}}});
    assign cq_y = DW'({cur_y, {FRAC_SHIFT{1'b0}}});
    assign pe_x = DW'(px_reg);
    assign pe_y = DW'(py_reg);
    assign ad_x = (pe_x >= cq_x) ? (pe_x - cq_x) : (cq_x - pe_x);
    assign ad_y = (pe_y >= cq_y) ? (pe_y - cq_y) : (cq_y - pe_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= '{valid: tag_in.valid, last: tag_in.last, picked: pos_picked};
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= idx_in;
        px_reg   <= prod_x[PROD_W-1:FRAC_SHIFT];
        py_reg   <= prod_y[PROD_W-1:FRAC_SHIFT];
        idx2_reg <= idx1_reg;
        ax_reg   <= ad_x;
        ay_reg   <= ad_y;
        idx3_reg <= idx2_reg;
        sqx_reg  <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sqy_reg  <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
    end

    assign tag_out = tag3_reg;
    assign idx_out = idx3_reg;
    assign sq_x    = sqx_reg;
    assign sq_y    = sqy_reg;

    // elaboration check that the cursor width fits the difference width
    localparam int CW_CHECK = (CW <= DW) ? 1 : 0;
    if (CW_CHECK == 0)
    begin : g_bad_width
        $error("cursor width exceeds difference width");
    end

endmodule

[rtl/npp_seq.sv]
// request sequencer: table writes, scan addressing, two running minima
`include "nearest_point_pick_assert.svh"

module npp_seq
    import npp_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int AW          = 8,
    parameter int PIXEL_BITS  = 12,
    parameter int SQ_W        = 42
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MODE_W-1:0]     mode,
    input  logic [INDEX_W-1:0]    entry_index,
    input  logic                  point_picked,
    input  logic [PIXEL_BITS-1:0] cursor_x,
    input  logic [PIXEL_BITS-1:0] cursor_y,
    input  logic [SIZE_W-1:0]     marker_size,
    input  logic [COUNT_W-1:0]    entry_count,
    output logic                  pos_we,
    output logic                  pick_we,
    output logic [AW-1:0]         wr_addr,
    output logic                  wr_pick,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    output scan_tag_t             tag_rd,
    output logic [AW-1:0]         idx_rd,
    output logic [PIXEL_BITS-1:0] cur_x,
    output logic [PIXEL_BITS-1:0] cur_y,
    input  scan_tag_t             pipe_tag,
    input  logic [AW-1:0]         pipe_idx,
    input  logic [SQ_W-1:0]       sq_x,
    input  logic [SQ_W-1:0]       sq_y,
    output logic                  done,
    output logic                  found,
    output logic [INDEX_W-1:0]    hit_index,
    output logic                  hit_was_picked
);

    localparam int DR_W = SQ_W + 1;
    localparam int EW   = AW + INDEX_W + 1;
    localparam int NW   = AW + COUNT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t               state_reg,      state_next;
    logic [AW-1:0]        cnt_reg,        cnt_next;
    logic [AW:0]          n_reg,          n_next;
    logic [MODE_W-1:0]    mode_reg,       mode_next;
    logic [PIXEL_BITS-1:0] cx_reg,        cx_next;
    logic [PIXEL_BITS-1:0] cy_reg,        cy_next;
    logic [LIMIT_W-1:0]   best_free_reg,  best_free_next;
    logic [LIMIT_W-1:0]   best_any_reg,   best_any_next;
    logic [AW-1:0]        free_idx_reg,   free_idx_next;
    logic [AW-1:0]        any_idx_reg,    any_idx_next;
    logic                 free_found_reg, free_found_next;
    logic                 any_found_reg,  any_found_next;
    logic                 any_pick_reg,   any_pick_next;
    scan_tag_t            tag_rd_reg,     tag_rd_next;
    logic [AW-1:0]        idx_rd_reg,     idx_rd_next;
    logic                 done_reg,       done_next;
    logic                 found_reg,      found_next;
    logic [INDEX_W-1:0]   hit_reg,        hit_next;
    logic                 was_reg,        was_next;

    logic                 accept;
    logic                 is_query;
    logic [EW-1:0]        wr_ext;
    logic                 wr_in_range;
    logic [NW-1:0]        cnt_ext;
    logic [AW:0]          n_sat;
    logic [LIMIT_W-1:0]   limit;
    logic [DR_W-1:0]      dr;
    logic                 lt_free;
    logic                 lt_any;
    logic                 scan_last;
    logic                 hit_found;
    logic [AW-1:0]        hit_sel;
    logic [EW-1:0]        hit_ext;
    logic                 mark_we;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign is_query = (mode == MODE_QUERY) || (mode == MODE_MARK);

    // write index range check
    assign wr_ext      = EW'(entry_index);
    assign wr_in_range = (wr_ext < EW'(MAX_ENTRIES));

    // entries in use, saturated to the table depth
    assign cnt_ext = NW'(entry_count);
    assign n_sat   = (cnt_ext > NW'(MAX_ENTRIES)) ? (AW+1)'(MAX_ENTRIES)
                                                  : cnt_ext[AW:0];

    // 0.25 * size^2 in q.16
    assign limit = LIMIT_W'(LIMIT_W'(marker_size) * LIMIT_W'(marker_size)) << LIMIT_SHIFT;

    // compare stage
    assign dr      = DR_W'(sq_x) + DR_W'(sq_y);
    assign lt_free = !pipe_tag.picked && (dr < DR_W'(best_free_reg));
    assign lt_any  = (dr < DR_W'(best_any_reg));

    assign scan_last = ({1'b0, cnt_reg} == (n_reg - (AW+1)'(1)));

    assign hit_found = free_found_reg || any_found_reg;
    assign hit_sel   = free_found_reg ? free_idx_reg : any_idx_reg;
    assign hit_ext   = EW'(hit_sel);

    assign mark_we = (state_reg == ST_DONE) && (mode_reg == MODE_MARK) && hit_found;

    // table write port: entry writes from idle, picked mark at the end of a mark query with a hit
    assign pos_we  = accept && (mode == MODE_WRITE) && wr_in_range;
    assign pick_we = pos_we || mark_we;
    assign wr_addr = mark_we ? hit_sel : wr_ext[AW-1:0];
    assign wr_pick = mark_we ? 1'b1 : point_picked;

    assign rd_en   = (state_reg == ST_SCAN);
    assign rd_addr = cnt_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        mode_next       = mode_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        best_free_next  = best_free_reg;
        best_any_next   = best_any_reg;
        free_idx_next   = free_idx_reg;
        any_idx_next    = any_idx_reg;
        free_found_next = free_found_reg;
        any_found_next  = any_found_reg;
        any_pick_next   = any_pick_reg;
        tag_rd_next     = '0;
        idx_rd_next     = idx_rd_reg;
        done_next       = 1'b0;
        found_next      = found_reg;
        hit_next        = hit_reg;
        was_next        = was_reg;

        if (pipe_tag.valid)
        begin
            if (lt_free)
            begin
                best_free_next  = dr[LIMIT_W-1:0];
                free_idx_next   = pipe_idx;
                free_found_next = 1'b1;
            end
            if (lt_any)
            begin
                best_any_next  = dr[LIMIT_W-1:0];
                any_idx_next   = pipe_idx;
                any_found_next = 1'b1;
                any_pick_next  = pipe_tag.picked;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    mode_next       = mode;
                    cx_next         = cursor_x;
                    cy_next         = cursor_y;
                    n_next          = n_sat;
                    cnt_next        = '0;
                    best_free_next  = limit;
                    best_any_next   = limit;
                    free_idx_next   = '0;
                    any_idx_next    = '0;
                    free_found_next = 1'b0;
                    any_found_next  = 1'b0;
                    any_pick_next   = 1'b0;
                    state_next      = (n_sat == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                tag_rd_next.valid = 1'b1;
                tag_rd_next.last  = scan_last;
                idx_rd_next       = cnt_reg;
                cnt_next          = cnt_reg + AW'(1);
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_tag.valid && pipe_tag.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done_next  = 1'b1;
                found_next = hit_found;
                hit_next   = hit_found ? hit_ext[INDEX_W-1:0] : '0;
                was_next   = !free_found_reg && any_found_reg && any_pick_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            n_reg          <= '0;
            mode_reg       <= MODE_QUERY;
            cx_reg         <= '0;
            cy_reg         <= '0;
            best_free_reg  <= '0;
            best_any_reg   <= '0;
            free_idx_reg   <= '0;
            any_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            any_found_reg  <= 1'b0;
            any_pick_reg   <= 1'b0;
            tag_rd_reg     <= '0;
            idx_rd_reg     <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            hit_reg        <= '0;
            was_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            mode_reg       <= mode_next;
            cx_reg         <= cx_next;
            cy_reg         <= cy_next;
            best_free_reg  <= best_free_next;
            best_any_reg   <= best_any_next;
            free_idx_reg   <= free_idx_next;
            any_idx_reg    <= any_idx_next;
            free_found_reg <= free_found_next;
            any_found_reg  <= any_found_next;
            any_pick_reg   <= any_pick_next;
            tag_rd_reg     <= tag_rd_next;
            idx_rd_reg     <= idx_rd_next;
            done_reg       <= done_next;
            found_reg      <= found_next;
            hit_reg        <= hit_next;
            was_reg        <= was_next;
        end
    end

    assign tag_rd         = tag_rd_reg;
    assign idx_rd         = idx_rd_reg;
    assign cur_x          = cx_reg;
    assign cur_y          = cy_reg;
    assign done           = done_reg;
    assign found          = found_reg;
    assign hit_index      = hit_reg;
    assign hit_was_picked = was_reg;

    `NPP_ASSERT_IMPLY(a_best_order, 1'b1, best_any_reg <= best_free_reg,
        "best overall distance above best unpicked distance")
    `NPP_ASSERT_IMPLY(a_free_needs_any, free_found_reg, any_found_reg,
        "unpicked hit without any hit")
    `NPP_ASSERT_IMPLY(a_pipe_in_scan, pipe_tag.valid,
        (state_reg == ST_SCAN) || (state_reg == ST_DRAIN),
        "scan data outside a scan")
    `NPP_ASSERT_IMPLY(a_done_after_finish, done_reg, $past(state_reg == ST_DONE),
        "result without a finished query")
    `NPP_ASSERT_NEXT(a_query_busy, accept && is_query, busy,
        "query accepted but block not busy")

endmodule

[tb/nearest_point_pick_checker.sv]
// checker for nearest_point_pick: predicts every query result and compares it with the block
`timescale 1ns / 1ps
module nearest_point_pick_checker
    import npp_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int PIXEL_W     = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [MODE_W-1:0]      mode,
    input  logic [INDEX_W-1:0]     entry_index,
    input  logic [POS_W-1:0]       point_x,
    input  logic [POS_W-1:0]       point_y,
    input  logic                   point_picked,
    input  logic [PIXEL_W-1:0]     cursor_x,
    input  logic [PIXEL_W-1:0]     cursor_y,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   done,
    input  logic                   found,
    input  logic [INDEX_W-1:0]     hit_index,
    input  logic                   hit_was_picked,
    output int                     mismatches,
    output int                     outstanding
);

    typedef struct {
        logic               found;
        logic [INDEX_W-1:0] hit_index;
        logic               hit_was_picked;
    } pick_t;

    logic [POS_W-1:0] table_x      [TABLE_DEPTH];
    logic [POS_W-1:0] table_y      [TABLE_DEPTH];
    logic             table_picked [TABLE_DEPTH];
    cfg_t             shadow_cfg;
    pick_t            pending_picks [$];
    pick_t            oldest_pick;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            table_x[i]      = '0;
            table_y[i]      = '0;
            table_picked[i] = 1'b0;
        end
    end

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatches++;
        $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // one pass keeping the nearest unpicked entry and the nearest of any kind
    function automatic pick_t pick_nearest(input logic [MODE_W-1:0] m,
                                           input logic [PIXEL_W-1:0] cx,
                                           input logic [PIXEL_W-1:0] cy);
        longint unsigned cxq, cyq, lim, best_free, best_any;
        longint unsigned px, py, dx, dy, dr, scale_w, scale_h, size;
        int    n, free_idx, any_idx, hit;
        bit    free_hit, any_hit;
        pick_t r;
        cxq = 64'(cx);
        cyq = 64'(cy);
        cxq = cxq << FRAC_SHIFT;
        cyq = cyq << FRAC_SHIFT;
        size = 64'(shadow_cfg.marker_size);
        lim = (size * size) << LIMIT_SHIFT;
        scale_w = 64'(shadow_cfg.image_width);
        scale_h = 64'(shadow_cfg.image_height);
        best_free = lim;
        best_any = lim;
        free_idx = 0;
        any_idx = 0;
        free_hit = 1'b0;
        any_hit = 1'b0;
        n = int'(shadow_cfg.entry_count);
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        for (int i = 0; i < n; i++)
        begin
            px = 64'(table_x[i]);
            py = 64'(table_y[i]);
            px = (px * scale_w) >> FRAC_SHIFT;
            py = (py * scale_h) >> FRAC_SHIFT;
            dx = (px >= cxq) ? px - cxq : cxq - px;
            dy = (py >= cyq) ? py - cyq : cyq - py;
            dr = dx * dx + dy * dy;
            if (!table_picked[i] && dr < best_free)
            begin
                best_free = dr;
                free_idx = i;
                free_hit = 1'b1;
            end
            if (dr < best_any)
            begin
                best_any = dr;
                any_idx = i;
                any_hit = 1'b1;
            end
        end
        hit = free_hit ? free_idx : any_idx;
        r.found = free_hit || any_hit;
        r.hit_index = r.found ? INDEX_W'(hit) : '0;
        r.hit_was_picked = r.found ? table_picked[hit] : 1'b0;
        if (r.found && m == MODE_MARK)
            table_picked[hit] = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_cfg.image_width  = RESET_IMAGE_WIDTH;
            shadow_cfg.image_height = RESET_IMAGE_HEIGHT;
            shadow_cfg.marker_size  = RESET_MARKER_SIZE;
            shadow_cfg.entry_count  = RESET_ENTRY_COUNT;
            pending_picks.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_picks.size() == 0)
                    flag_mismatch("result with no query waiting, hit_index",
                                  16'(hit_index), 16'd0);
                else
                begin
                    oldest_pick = pending_picks.pop_front();
                    if (found !== oldest_pick.found)
                        flag_mismatch("found", 16'(found), 16'(oldest_pick.found));
                    if (hit_index !== oldest_pick.hit_index)
                        flag_mismatch("hit_index", 16'(hit_index),
                                      16'(oldest_pick.hit_index));
                    if (hit_was_picked !== oldest_pick.hit_was_picked)
                        flag_mismatch("hit_was_picked", 16'(hit_was_picked),
                                      16'(oldest_pick.hit_was_picked));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  shadow_cfg.image_width  = cfg_data[SCALE_W-1:0];
                    REG_IMAGE_HEIGHT: shadow_cfg.image_height = cfg_data[SCALE_W-1:0];
                    REG_MARKER_SIZE:  shadow_cfg.marker_size  = cfg_data[SIZE_W-1:0];
                    REG_ENTRY_COUNT:  shadow_cfg.entry_count  = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (mode)
                    MODE_WRITE:
                    begin
                        table_x[entry_index]      = point_x;
                        table_y[entry_index]      = point_y;
                        table_picked[entry_index] = point_picked;
                    end
                    MODE_QUERY, MODE_MARK:
                        pending_picks.push_back(pick_nearest(mode, cursor_x, cursor_y));
                    default: ;
                endcase
            end
            outstanding <= pending_picks.size();
        end
    end

endmodule

[tb/nearest_point_pick_tb.sv]
// testbench top for nearest_point_pick: request stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module nearest_point_pick_tb;
    import npp_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int PIXEL_W     = 12;
    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 1500000;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [MODE_W-1:0]      mode;
    logic [INDEX_W-1:0]     entry_index;
    logic [POS_W-1:0]       point_x;
    logic [POS_W-1:0]       point_y;
    logic                   point_picked;
    logic [PIXEL_W-1:0]     cursor_x;
    logic [PIXEL_W-1:0]     cursor_y;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   done;
    logic                   found;
    logic [INDEX_W-1:0]     hit_index;
    logic                   hit_was_picked;

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    bit written [TABLE_DEPTH];
    int filled = 0;
    int items_sent = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;

    nearest_point_pick #(
        .MAX_ENTRIES(TABLE_DEPTH),
        .PIXEL_BITS (PIXEL_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .entry_index   (entry_index),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_picked  (point_picked),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .found         (found),
        .hit_index     (hit_index),
        .hit_was_picked(hit_was_picked)
    );

    nearest_point_pick_checker #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .PIXEL_W    (PIXEL_W)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .entry_index   (entry_index),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_picked  (point_picked),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .found         (found),
        .hit_index     (hit_index),
        .hit_was_picked(hit_was_picked),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("nearest_point_pick verification failed");
            $finish;
        end
    end

    // Q0.16 fraction that lands within spread pixels of center at this scale
    function automatic logic [POS_W-1:0] frac_near(input int center, input int scale,
                                                   input int spread);
        longint base;
        longint v;
        int     rad;
        int     off;
        if (scale == 0)
            return POS_W'($urandom);
        base = (longint'(center) * 65536) / scale;
        rad = (spread * 65536) / scale + 1;
        if (rad > 65535)
            rad = 65535;
        off = $urandom_range(0, 2 * rad);
        off -= rad;
        v = base + off;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return POS_W'(v);
    endfunction

    function automatic logic [PIXEL_W-1:0] cursor_near(input int center, input int spread);
        int c;
        int off;
        off = $urandom_range(0, 2 * spread);
        c = center + off - spread;
        if (c < 0)
            c = 0;
        if (c > 4095)
            c = 4095;
        return PIXEL_W'(c);
    endfunction

    function automatic int pick_scale();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 1;
            1: return 4096;
            2: return 0;
            3: return 8191;
            4: return $urandom_range(4097, 8191);
            default: return $urandom_range(64, 4096);
        endcase
    endfunction

    task automatic pace();
        int gap;
        if (!gaps_on)
            return;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                start = 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] idx,
                                input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                input logic pk, input logic [PIXEL_W-1:0] cx,
                                input logic [PIXEL_W-1:0] cy);
        pace();
        @(negedge clk);
        start = 1'b1;
        mode = m;
        entry_index = idx;
        point_x = x;
        point_y = y;
        point_picked = pk;
        cursor_x = cx;
        cursor_y = cy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_entry(input int idx, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y, input logic pk);
        send_request(MODE_WRITE, INDEX_W'(idx), x, y, pk, PIXEL_W'($urandom),
                     PIXEL_W'($urandom));
        written[idx] = 1'b1;
        while (filled < TABLE_DEPTH && written[filled])
            filled++;
        items_sent++;
    endtask

    task automatic query(input logic [MODE_W-1:0] m, input logic [PIXEL_W-1:0] cx,
                         input logic [PIXEL_W-1:0] cy);
        send_request(m, INDEX_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     1'($urandom_range(0, 1)), cx, cy);
        if (m != MODE_UNUSED)
            items_sent++;
    endtask

    // hold off until every query result is back and the block is quiet
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(input int w, input int h, input int sz, input int cnt);
        int n, k, nq, r, spread, center_x, center_y;
        logic [POS_W-1:0] px, py;
        logic [MODE_W-1:0] m;
        settle();
        gaps_on = ($urandom_range(0, 4) != 0);
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
        cfg_write(REG_MARKER_SIZE, sz);
        cfg_write(REG_ENTRY_COUNT, cnt);
        n = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
        center_x = (w == 0) ? 0 : $urandom_range(0, ((w > 4096) ? 4096 : w) - 1);
        center_y = (h == 0) ? 0 : $urandom_range(0, ((h > 4096) ? 4096 : h) - 1);
        spread = sz / 2 + 2;
        while (filled < n)
        begin
            if ($urandom_range(0, 1))
                write_entry(filled, frac_near(center_x, w, spread),
                            frac_near(center_y, h, spread), 1'($urandom_range(0, 1)));
            else
                write_entry(filled, POS_W'($urandom), POS_W'($urandom),
                            1'($urandom_range(0, 1)));
        end
        // cluster some entries around the cursor area, with repeated positions for ties
        px = frac_near(center_x, w, spread);
        py = frac_near(center_y, h, spread);
        k = $urandom_range(0, (n < 6) ? n : 6);
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                px = frac_near(center_x, w, spread);
                py = frac_near(center_y, h, spread);
            end
            write_entry($urandom_range(0, n - 1), px, py, $urandom_range(0, 9) < 3);
        end
        nq = (n > 64) ? $urandom_range(3, 6) : $urandom_range(8, 24);
        for (int j = 0; j < nq; j++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                write_entry($urandom_range(0, TABLE_DEPTH - 1), POS_W'($urandom),
                            POS_W'($urandom), 1'($urandom_range(0, 1)));
            else if (r < 12)
                query(MODE_UNUSED, PIXEL_W'($urandom), PIXEL_W'($urandom));
            else
            begin
                m = $urandom_range(0, 1) ? MODE_MARK : MODE_QUERY;
                if ($urandom_range(0, 3) != 0)
                    query(m, cursor_near(center_x, spread), cursor_near(center_y, spread));
                else
                    query(m, PIXEL_W'($urandom), PIXEL_W'($urandom));
            end
        end
    endtask

    initial
    begin
        int w, h, sz, cnt, r;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_WRITE;
        entry_index = '0;
        point_x = '0;
        point_y = '0;
        point_picked = 1'b0;
        cursor_x = '0;
        cursor_y = '0;
        cfg_we = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset scaling: one pixel is 64 steps of the fraction, pick radius 8 pixels
        write_entry(0, 16'd0, 16'd0, 1'b0);
        write_entry(1, 16'hFFFF, 16'hFFFF, 1'b1);
        write_entry(2, 16'd6400, 16'd6400, 1'b1);
        write_entry(3, 16'd6400, 16'd6400, 1'b0);
        write_entry(4, 16'd6400, 16'd6400, 1'b0);
        write_entry(5, 16'd12800, 16'd12800, 1'b1);
        write_entry(6, 16'd12992, 16'd12800, 1'b0);
        write_entry(7, 16'd19712, 16'd19200, 1'b0);
        settle();
        cfg_write(REG_ENTRY_COUNT, 8);
        query(MODE_QUERY, 12'd0, 12'd0);
        query(MODE_QUERY, 12'd4095, 12'd4095);
        query(MODE_QUERY, 12'd1023, 12'd1023);
        query(MODE_MARK, 12'd100, 12'd100);
        query(MODE_QUERY, 12'd100, 12'd100);
        query(MODE_MARK, 12'd100, 12'd100);
        query(MODE_QUERY, 12'd100, 12'd100);
        query(MODE_QUERY, 12'd200, 12'd200);
        // exactly on the radius is outside, one pixel closer is inside
        query(MODE_QUERY, 12'd300, 12'd300);
        query(MODE_QUERY, 12'd301, 12'd300);
        query(MODE_UNUSED, 12'd100, 12'd100);

        run_phase(4096, 4096, 255, 256);
        run_phase(1, 1, 0, 0);
        run_phase(8191, 0, 200, 511);
        run_phase(1024, 1024, 1, 16);

        while (items_sent < ITEM_TARGET)
        begin
            w = pick_scale();
            h = pick_scale();
            r = $urandom_range(0, 99);
            if (r < 5)
                sz = 0;
            else if (r < 10)
                sz = 255;
            else if (r < 15)
                sz = 1;
            else
                sz = $urandom_range(2, 64);
            r = $urandom_range(0, 99);
            if (r < 4)
                cnt = 0;
            else if (r < 10)
                cnt = $urandom_range(200, 511);
            else
                cnt = $urandom_range(1, 24);
            run_phase(w, h, sz, cnt);
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("nearest_point_pick verification clean");
        else
            $display("nearest_point_pick verification failed");
        $finish;
    end

endmodule
